FILE: rtl/rvn_pkg.sv
`default_nettype none

package rvn_pkg;

   // Word field widths.
   localparam int DATA_W = 16;
   localparam int EPS_W  = 24;

   // Datapath widths: sum of squares Q13.24, mean square with epsilon,
   // divider dividend (2^64 needs 65 bits), radicand and reciprocal root.
   localparam int SUM_W  = 37;
   localparam int SQ_W   = 31;
   localparam int MEAN_W = 38;
   localparam int DIV_W  = 65;
   localparam int RAD_W  = 64;
   localparam int INV_W  = 32;
   localparam int PROD_W = 32;
   localparam int BIG_W  = 63;

   // Iteration counts of the serial divider and square root units.
   localparam int DIV_STEPS  = 65;
   localparam int SQRT_STEPS = 32;
   localparam int ITER_W     = 7;

   // Configuration register file.
   localparam int                 CSR_ADDR_W = 3;
   localparam logic               REG_EPS    = 1'b0;
   localparam logic [EPS_W-1:0]   EPS_RESET  = 24'd168;

   typedef struct packed {
      logic take;
      logic div_load_mean;
      logic div_load_recip;
      logic div_step;
      logic mean_load;
      logic sqrt_load;
      logic sqrt_step;
      logic inv_load;
      logic inv_ones;
      logic rd_issue;
      logic mul_step;
      logic prod_step;
      logic out_load;
      logic idx_next;
      logic vec_clear;
   } rvn_cmd_type;

   typedef struct packed {
      logic ends_vec;
      logic mean_small;
      logic elem_last;
   } rvn_stat_type;

endpackage

`default_nettype wire

FILE: rtl/rvn_if.sv
`default_nettype none

interface rvn_req_if import rvn_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sample;
   logic signed [DATA_W-1:0] weight;
   logic                     last;

   modport source (output valid, sample, weight, last, input ready);
   modport sink   (input valid, sample, weight, last, output ready);
endinterface

interface rvn_rsp_if import rvn_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] norm_value;
   logic                     clipped;
   logic                     end_of_vector;

   modport source (output valid, norm_value, clipped, end_of_vector, input ready);
   modport sink   (input valid, norm_value, clipped, end_of_vector, output ready);
endinterface

`default_nettype wire

FILE: rtl/rms_vector_normalizer.sv
`default_nettype none

// RMS normalizer for vectors of up to VECTOR_MAX elements. Each input word
// carries a signed Q4.12 sample and weight; the block stores the pair and
// accumulates the sum of squares, taking one word per clock. The word marked
// last, or the word that fills the store, ends the vector. The block then
// computes the mean square (sum divided by the count, plus eps_value), the
// reciprocal square root in Q12.20, and returns one result word per stored
// element in order: sample times weight times that reciprocal, rounded to
// Q4.12 half away from zero and saturated, with a clip flag and an end flag
// on the final word. The normalization phase uses one shared serial divider
// at one bit per cycle, for the mean and, unless the mean square is at most
// 1, for the reciprocal, which feeds a serial square root unit; each result
// then passes through a store read, two registered multiplies, rounding and
// a hand-off that waits while the result side holds off ready. No input
// word is taken from the end of a vector until its last result is delivered.
// eps_value sits at byte address 0 of the APB port and resets to 168.

module rms_vector_normalizer import rvn_pkg::*; #(
   parameter int VECTOR_MAX = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   rvn_req_if.sink               req_stream,
   rvn_rsp_if.source             rsp_stream,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   rvn_cmd_type      cmd;
   rvn_stat_type     stat;
   logic [EPS_W-1:0] eps_ff;

   // Configuration register: written in the access phase of an APB write.
   // The register index is the word address; other indexes are ignored.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_EPS) ? 32'(eps_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == REG_EPS)) begin
         eps_ff <= pwdata[EPS_W-1:0];
      end
   end

   // The controller sequences accumulation, the serial math units and the
   // result loop; the datapath owns the store and all arithmetic.
   rvn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_stream.valid),
      .req_ready (req_stream.ready),
      .rsp_valid (rsp_stream.valid),
      .rsp_ready (rsp_stream.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rvn_datapath #(
      .VECTOR_MAX (VECTOR_MAX)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_sample        (req_stream.sample),
      .req_weight        (req_stream.weight),
      .req_last          (req_stream.last),
      .eps_value         (eps_ff),
      .rsp_norm_value    (rsp_stream.norm_value),
      .rsp_clipped       (rsp_stream.clipped),
      .rsp_end_of_vector (rsp_stream.end_of_vector)
   );

endmodule

`default_nettype wire

FILE: rtl/rvn_datapath.sv
`default_nettype none

module rvn_datapath import rvn_pkg::*; #(
   parameter int VECTOR_MAX = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rvn_cmd_type              cmd,
   output rvn_stat_type             stat,
   input  logic signed [DATA_W-1:0] req_sample,
   input  logic signed [DATA_W-1:0] req_weight,
   input  logic                     req_last,
   input  logic [EPS_W-1:0]         eps_value,
   output logic signed [DATA_W-1:0] rsp_norm_value,
   output logic                     rsp_clipped,
   output logic                     rsp_end_of_vector
);

   localparam int ADDR_W = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1;
   localparam int CNT_W  = $clog2(VECTOR_MAX + 1);

   logic [DATA_W-1:0] sample_mem [VECTOR_MAX];
   logic [DATA_W-1:0] weight_mem [VECTOR_MAX];

   logic [CNT_W-1:0]         count_ff, idx_ff;
   logic                     sq_pend_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic signed [PROD_W-1:0] sq_full;

   logic [DIV_W-1:0]  dq_ff;
   logic [MEAN_W-1:0] dr_ff, dd_ff, mean_ff;
   logic [MEAN_W:0]   d_trial, d_diff;
   logic              d_bit;

   logic [RAD_W-1:0]  sx_ff;
   logic [INV_W-1:0]  sr_ff;
   logic [INV_W+1:0]  s_trial, s_test;
   logic [INV_W-1:0]  so_ff, inv_ff;
   logic              s_bit;

   logic signed [DATA_W-1:0] s_rd_ff, w_rd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [SQ_W-1:0]          p_mag;
   logic [BIG_W-1:0]         big_ff, big_rnd;
   logic                     neg_ff;
   logic [SQ_W-1:0]          r_val, r_lim, r_sat;
   logic                     r_clip;

   // Element store, written while accumulating and read one entry at a time.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sample_mem[count_ff[ADDR_W-1:0]] <= req_sample;
         weight_mem[count_ff[ADDR_W-1:0]] <= req_weight;
      end
      if (cmd.rd_issue) begin
         s_rd_ff <= signed'(sample_mem[idx_ff[ADDR_W-1:0]]);
         w_rd_ff <= signed'(weight_mem[idx_ff[ADDR_W-1:0]]);
      end
   end

   assign sq_full = req_sample * req_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         idx_ff     <= '0;
         sq_pend_ff <= 1'b0;
         sum_ff     <= '0;
      end else begin
         sq_pend_ff <= cmd.take;
         if (cmd.take) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.vec_clear) begin
            count_ff <= '0;
         end
         if (cmd.vec_clear) begin
            sum_ff <= '0;
         end else if (sq_pend_ff) begin
            sum_ff <= sum_ff + SUM_W'(sq_ff);
         end
         if (cmd.vec_clear) begin
            idx_ff <= '0;
         end else if (cmd.idx_next) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sq_ff <= sq_full[SQ_W-1:0];
      end
   end

   // Restoring divider, one quotient bit per step.
   assign d_trial = {dr_ff, dq_ff[DIV_W-1]};
   assign d_diff  = d_trial - {1'b0, dd_ff};
   assign d_bit   = (d_trial >= {1'b0, dd_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_load_mean) begin
         dq_ff <= DIV_W'(sum_ff);
         dr_ff <= '0;
         dd_ff <= MEAN_W'(count_ff);
      end else if (cmd.div_load_recip) begin
         dq_ff <= {1'b1, {(DIV_W-1){1'b0}}};
         dr_ff <= '0;
         dd_ff <= mean_ff;
      end else if (cmd.div_step) begin
         dq_ff <= {dq_ff[DIV_W-2:0], d_bit};
         dr_ff <= d_bit ? d_diff[MEAN_W-1:0] : d_trial[MEAN_W-1:0];
      end
      if (cmd.mean_load) begin
         mean_ff <= dq_ff[MEAN_W-1:0] + MEAN_W'(eps_value);
      end
   end

   // Digit-by-digit square root, one root bit per step. The partial
   // remainder stays below 2^32 before every step that reads it.
   assign s_trial = {sr_ff, sx_ff[RAD_W-1:RAD_W-2]};
   assign s_test  = {so_ff, 2'b01};
   assign s_bit   = (s_trial >= s_test);

   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         sx_ff <= dq_ff[RAD_W-1:0];
         sr_ff <= '0;
         so_ff <= '0;
      end else if (cmd.sqrt_step) begin
         sx_ff <= {sx_ff[RAD_W-3:0], 2'b00};
         sr_ff <= INV_W'(s_bit ? (s_trial - s_test) : s_trial);
         so_ff <= {so_ff[INV_W-2:0], s_bit};
      end
      if (cmd.inv_ones) begin
         inv_ff <= '1;
      end else if (cmd.inv_load) begin
         inv_ff <= so_ff;
      end
   end

   // Output scaling: product, times reciprocal, round and saturate.
   assign p_mag   = prod_ff[PROD_W-1] ? SQ_W'(-prod_ff) : prod_ff[SQ_W-1:0];
   assign big_rnd = big_ff + (BIG_W'(1) << 31);
   assign r_val   = big_rnd[BIG_W-1:32];
   assign r_lim   = neg_ff ? SQ_W'(32768) : SQ_W'(32767);
   assign r_clip  = (r_val > r_lim);
   assign r_sat   = r_clip ? r_lim : r_val;

   always_ff @(posedge clock) begin
      if (cmd.mul_step) begin
         prod_ff <= s_rd_ff * w_rd_ff;
      end
      if (cmd.prod_step) begin
         neg_ff <= prod_ff[PROD_W-1];
         big_ff <= BIG_W'(p_mag) * BIG_W'(inv_ff);
      end
      if (cmd.out_load) begin
         rsp_norm_value    <= neg_ff ? signed'(~r_sat[DATA_W-1:0] + DATA_W'(1))
                                     : signed'(r_sat[DATA_W-1:0]);
         rsp_clipped       <= r_clip;
         rsp_end_of_vector <= stat.elem_last;
      end
   end

   assign stat.ends_vec   = req_last || ((count_ff + CNT_W'(1)) == CNT_W'(VECTOR_MAX));
   assign stat.mean_small = (mean_ff <= MEAN_W'(1));
   assign stat.elem_last  = ((idx_ff + CNT_W'(1)) == count_ff);

endmodule

`default_nettype wire

FILE: rtl/rvn_ctrl.sv
`default_nettype none

module rvn_ctrl import rvn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  rvn_stat_type stat,
   output rvn_cmd_type  cmd
);

   localparam logic [3:0] ST_ACC   = 4'd0;
   localparam logic [3:0] ST_FLUSH = 4'd1;
   localparam logic [3:0] ST_DLD   = 4'd2;
   localparam logic [3:0] ST_DIV1  = 4'd3;
   localparam logic [3:0] ST_MEAN  = 4'd4;
   localparam logic [3:0] ST_CHK   = 4'd5;
   localparam logic [3:0] ST_DIV2  = 4'd6;
   localparam logic [3:0] ST_SQLD  = 4'd7;
   localparam logic [3:0] ST_SQRT  = 4'd8;
   localparam logic [3:0] ST_INV   = 4'd9;
   localparam logic [3:0] ST_RD    = 4'd10;
   localparam logic [3:0] ST_MUL   = 4'd11;
   localparam logic [3:0] ST_PROD  = 4'd12;
   localparam logic [3:0] ST_OUT   = 4'd13;
   localparam logic [3:0] ST_WAIT  = 4'd14;

   logic [3:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              iter_done;

   assign iter_done = (iter_ff == '0);

   always_comb begin
      state_in  = state_ff;
      iter_in   = iter_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_ACC: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (stat.ends_vec) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            state_in = ST_DLD;
         end
         ST_DLD: begin
            cmd.div_load_mean = 1'b1;
            iter_in           = ITER_W'(DIV_STEPS - 1);
            state_in          = ST_DIV1;
         end
         ST_DIV1: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff - ITER_W'(1);
            if (iter_done) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            cmd.mean_load = 1'b1;
            state_in      = ST_CHK;
         end
         ST_CHK: begin
            if (stat.mean_small) begin
               cmd.inv_ones = 1'b1;
               state_in     = ST_RD;
            end else begin
               cmd.div_load_recip = 1'b1;
               iter_in            = ITER_W'(DIV_STEPS - 1);
               state_in           = ST_DIV2;
            end
         end
         ST_DIV2: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff - ITER_W'(1);
            if (iter_done) begin
               state_in = ST_SQLD;
            end
         end
         ST_SQLD: begin
            cmd.sqrt_load = 1'b1;
            iter_in       = ITER_W'(SQRT_STEPS - 1);
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            iter_in       = iter_ff - ITER_W'(1);
            if (iter_done) begin
               state_in = ST_INV;
            end
         end
         ST_INV: begin
            cmd.inv_load = 1'b1;
            state_in     = ST_RD;
         end
         ST_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod_step = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            cmd.out_load = 1'b1;
            state_in     = ST_WAIT;
         end
         ST_WAIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (stat.elem_last) begin
                  cmd.vec_clear = 1'b1;
                  state_in      = ST_ACC;
               end else begin
                  cmd.idx_next = 1'b1;
                  state_in     = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result sides active together");

   a_end_starts_math: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && req_valid && stat.ends_vec) |=> (state_ff == ST_FLUSH))
      else $error("vector end did not start the normalization");

   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT && rsp_ready && stat.elem_last) |=> req_ready)
      else $error("block did not return to accumulation after last result");

endmodule

`default_nettype wire
